>>> sv/gfhr_pkg.sv
// ----------------------------------------------------------------------------
// Gamepad frame to HID report: shared package
// Word types, command codes, register indexes and protocol constants used by
// the front end, the back end and the top level.
// ----------------------------------------------------------------------------
package gfhr_pkg;

   // Frame capture.
   localparam int CAP_DEPTH     = 18;
   localparam int POS_WIDTH     = 5;
   localparam int POS_MAX       = 31;
   localparam int STATE_MIN_LEN = 20;
   localparam int GUIDE_MIN_LEN = 6;

   // Frame signature bytes.
   localparam logic [7:0] STATE_TAG    = 8'h20;
   localparam logic [7:0] GUIDE_TAG0   = 8'h07;
   localparam logic [7:0] GUIDE_TAG1   = 8'h20;
   localparam logic [7:0] GUIDE_TAG3   = 8'h02;
   localparam logic [7:0] GUIDE_TAG5   = 8'h5B;

   // Report constants.
   localparam logic [3:0] HAT_NEUTRAL      = 4'hF;
   localparam int         GUIDE_BUTTON_BIT = 8;

   // Input actions.
   localparam logic ACTION_BYTE = 1'b0;
   localparam logic ACTION_TICK = 1'b1;

   // Configuration registers.
   localparam int          CSR_INDEX_WIDTH     = 1;
   localparam int          CSR_DATA_WIDTH      = 16;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_LATCH_TICKS   = 1'd0;
   localparam logic [CSR_INDEX_WIDTH-1:0] CSR_TRIGGER_FLOOR = 1'd1;
   localparam logic [15:0] LATCH_TICKS_RESET   = 16'd60;
   localparam logic [15:0] TRIGGER_FLOOR_RESET = 16'd8;

   // Queue depths.
   localparam int CMD_DEPTH_DEFAULT = 4;
   localparam int RSP_DEPTH_DEFAULT = 2;

   // Command kinds passed from the front end to the back end.
   localparam logic [1:0] CMD_TICK  = 2'd0;
   localparam logic [1:0] CMD_GUIDE = 2'd1;
   localparam logic [1:0] CMD_STATE = 2'd2;

   typedef struct packed {
      logic       action;
      logic [7:0] data_byte;
      logic       frame_end;
   } req_word_type;

   typedef struct packed {
      logic [10:0]       buttons;
      logic [3:0]        hat;
      logic signed [7:0] left_x;
      logic signed [7:0] left_y;
      logic signed [7:0] right_x;
      logic signed [7:0] right_y;
      logic [7:0]        left_trigger;
      logic [7:0]        right_trigger;
   } rsp_word_type;

   typedef struct packed {
      logic [1:0]  kind;
      logic        pressed;
      logic [7:0]  b4;
      logic [7:0]  b5;
      logic [15:0] lt_raw;
      logic [15:0] rt_raw;
      logic [15:0] lx_raw;
      logic [15:0] ly_raw;
      logic [15:0] rx_raw;
      logic [15:0] ry_raw;
   } cmd_type;

endpackage

>>> sv/gamepad_frame_to_hid_report_unit.sv
// ----------------------------------------------------------------------------
// Gamepad frame to HID report unit
// Turns controller frames, delivered one byte per word, into HID reports.
// ----------------------------------------------------------------------------
// Usage:
// The request channel is written like a queue: a word (a frame byte with its
// end marker, or a timer tick) is taken at each clock edge with req_push high
// and req_full low. Reports come out of a queue: while rsp_empty is low the
// oldest report sits on rsp_word and rsp_pop takes it.
// The csr port writes latch_ticks (index 0) and trigger_floor (index 1);
// write them only while no report is pending.
// Throughput is one word per cycle while req_full is low. A frame's last byte
// is classified in the cycle it is taken and enters the command queue at that
// edge; once it heads the command queue and the report queue has room, the back
// end maps it and writes the report queue, whose head is rsp_word. Ticks pass
// through the same command queue so their order with guide events is kept.
// When the receiver stalls, the report queue fills, the back end halts at the
// first command that needs a report, and once the command queue is full req_full
// goes high. Reset empties both queues, restarts frame capture and clears the
// guide state and the remembered report; registers return to 60 and 8.
// ----------------------------------------------------------------------------
module gamepad_frame_to_hid_report_unit #(
   parameter int CMD_DEPTH = gfhr_pkg::CMD_DEPTH_DEFAULT,
   parameter int RSP_DEPTH = gfhr_pkg::RSP_DEPTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_push,
   output logic                                   req_full,
   input  gfhr_pkg::req_word_type                 req_word,
   output logic                                   rsp_empty,
   input  logic                                   rsp_pop,
   output gfhr_pkg::rsp_word_type                 rsp_word,
   input  logic                                   csr_we,
   input  logic [gfhr_pkg::CSR_INDEX_WIDTH-1:0]   csr_index,
   input  logic [gfhr_pkg::CSR_DATA_WIDTH-1:0]    csr_wdata
);

   localparam int CMD_WIDTH = $bits(gfhr_pkg::cmd_type);
   localparam int RSP_WIDTH = $bits(gfhr_pkg::rsp_word_type);

   logic [15:0] latch_ticks_ff, latch_ticks_in;
   logic [15:0] trigger_floor_ff, trigger_floor_in;

   logic                   req_accept;
   logic                   cmd_push;
   gfhr_pkg::cmd_type      cmd_in_word;
   logic [CMD_WIDTH-1:0]   cmd_out_bits;
   gfhr_pkg::cmd_type      cmd_out_word;
   logic                   cmd_empty;
   logic                   cmd_full;
   logic                   cmd_pop;
   logic                   rsp_push;
   gfhr_pkg::rsp_word_type rsp_in_word;
   logic [RSP_WIDTH-1:0]   rsp_out_bits;
   logic                   rsp_full;

   assign req_accept   = req_push && !req_full;
   assign req_full     = cmd_full;
   assign cmd_out_word = gfhr_pkg::cmd_type'(cmd_out_bits);
   assign rsp_word     = gfhr_pkg::rsp_word_type'(rsp_out_bits);

   // Configuration registers.
   always_comb begin
      latch_ticks_in   = latch_ticks_ff;
      trigger_floor_in = trigger_floor_ff;
      if (csr_we) begin
         unique case (csr_index)
            gfhr_pkg::CSR_LATCH_TICKS:   latch_ticks_in   = csr_wdata;
            gfhr_pkg::CSR_TRIGGER_FLOOR: trigger_floor_in = csr_wdata;
            default: begin
               latch_ticks_in = latch_ticks_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         latch_ticks_ff   <= gfhr_pkg::LATCH_TICKS_RESET;
         trigger_floor_ff <= gfhr_pkg::TRIGGER_FLOOR_RESET;
      end else begin
         latch_ticks_ff   <= latch_ticks_in;
         trigger_floor_ff <= trigger_floor_in;
      end
   end

   // Front end: byte capture and frame classification.
   gfhr_front u_front (
      .clock    (clock),
      .reset    (reset),
      .accept   (req_accept),
      .req_word (req_word),
      .cmd_push (cmd_push),
      .cmd_word (cmd_in_word)
   );

   // Command queue between the front end and the back end.
   gfhr_fifo #(
      .WIDTH (CMD_WIDTH),
      .DEPTH (CMD_DEPTH)
   ) u_cmd_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (cmd_push),
      .wr_data (cmd_in_word),
      .pop     (cmd_pop),
      .rd_data (cmd_out_bits),
      .empty   (cmd_empty),
      .full    (cmd_full)
   );

   // Back end: guide state, latch and report mapping.
   gfhr_back u_back (
      .clock         (clock),
      .reset         (reset),
      .cmd_valid     (!cmd_empty),
      .cmd_word      (cmd_out_word),
      .cmd_pop       (cmd_pop),
      .rsp_full      (rsp_full),
      .rsp_push      (rsp_push),
      .rsp_word      (rsp_in_word),
      .latch_ticks   (latch_ticks_ff),
      .trigger_floor (trigger_floor_ff)
   );

   // Report queue; it decouples the back end from the receiver.
   gfhr_fifo #(
      .WIDTH (RSP_WIDTH),
      .DEPTH (RSP_DEPTH)
   ) u_rsp_fifo (
      .clock   (clock),
      .reset   (reset),
      .push    (rsp_push),
      .wr_data (rsp_in_word),
      .pop     (rsp_pop && !rsp_empty),
      .rd_data (rsp_out_bits),
      .empty   (rsp_empty),
      .full    (rsp_full)
   );

`ifndef NO_ASSERTIONS
   // A tick taken by the back end never produces a report.
   assert property (@(posedge clock) disable iff (reset)
      (cmd_pop && (cmd_out_word.kind == gfhr_pkg::CMD_TICK)) |-> !rsp_push)
      else $error("tick command produced a report");

   // The back end never writes into a full report queue.
   assert property (@(posedge clock) disable iff (reset)
      rsp_push |-> (!rsp_full || (rsp_pop && !rsp_empty)))
      else $error("report written into a full queue");

   // The front end only issues commands for taken words, so never into a full queue.
   assert property (@(posedge clock) disable iff (reset)
      cmd_push |-> (req_accept && !cmd_full))
      else $error("command issued without an accepted word");

   // After reset the report queue is empty and the command queue is not full.
   assert property (@(posedge clock)
      reset |=> (rsp_empty && !req_full))
      else $error("queues not empty after reset");
`endif

endmodule

>>> sv/gfhr_fifo.sv
// ----------------------------------------------------------------------------
// Gamepad frame to HID report: small synchronous queue
// Register-based first-in first-out queue with a count; the head word is
// presented combinationally. DEPTH must be at least 2.
// ----------------------------------------------------------------------------
module gfhr_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             push,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             pop,
   output logic [WIDTH-1:0] rd_data,
   output logic             empty,
   output logic             full
);

   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   assign rd_data = mem_ff[rd_ptr_ff];
   assign empty   = (count_ff == '0);
   assign full    = (count_ff == CW'(DEPTH));

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == AW'(DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == AW'(DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

>>> sv/gfhr_front.sv
// ----------------------------------------------------------------------------
// Gamepad frame to HID report: front end
// Captures frame bytes, and at the end of a frame classifies it as a state
// frame, a guide event or neither. Ticks and recognized frames leave as
// commands for the back end.
// ----------------------------------------------------------------------------
module gfhr_front (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  accept,
   input  gfhr_pkg::req_word_type req_word,
   output logic                  cmd_push,
   output gfhr_pkg::cmd_type     cmd_word
);

   logic [gfhr_pkg::POS_WIDTH-1:0] pos_ff, pos_in;
   logic [7:0] cap_ff [gfhr_pkg::CAP_DEPTH];
   logic [7:0] cap_in [gfhr_pkg::CAP_DEPTH];
   logic [7:0] eff    [gfhr_pkg::CAP_DEPTH];
   logic [gfhr_pkg::POS_WIDTH-1:0] len;
   logic       byte_accept;
   logic       is_guide;
   logic       is_state;

   assign byte_accept = accept && (req_word.action == gfhr_pkg::ACTION_BYTE);

   // Length of the frame including this byte; the count saturates.
   assign len = (pos_ff < gfhr_pkg::POS_WIDTH'(gfhr_pkg::POS_MAX)) ?
                pos_ff + 1'b1 : gfhr_pkg::POS_WIDTH'(gfhr_pkg::POS_MAX);

   always_comb begin
      // The byte being accepted now is not yet in the capture registers.
      for (int k = 0; k < gfhr_pkg::CAP_DEPTH; k++) begin
         eff[k]    = (pos_ff == gfhr_pkg::POS_WIDTH'(k)) ? req_word.data_byte : cap_ff[k];
         cap_in[k] = (byte_accept && (pos_ff == gfhr_pkg::POS_WIDTH'(k))) ?
                     req_word.data_byte : cap_ff[k];
      end
      pos_in = pos_ff;
      if (byte_accept) begin
         pos_in = req_word.frame_end ? '0 : len;
      end
   end

   always_comb begin
      is_guide = (len >= gfhr_pkg::POS_WIDTH'(gfhr_pkg::GUIDE_MIN_LEN))
              && (eff[0] == gfhr_pkg::GUIDE_TAG0) && (eff[1] == gfhr_pkg::GUIDE_TAG1)
              && (eff[3] == gfhr_pkg::GUIDE_TAG3) && (eff[5] == gfhr_pkg::GUIDE_TAG5);
      is_state = (len >= gfhr_pkg::POS_WIDTH'(gfhr_pkg::STATE_MIN_LEN))
              && (eff[0] == gfhr_pkg::STATE_TAG);

      cmd_word.kind    = gfhr_pkg::CMD_TICK;
      cmd_word.pressed = (eff[4] != 8'h00);
      cmd_word.b4      = eff[4];
      cmd_word.b5      = eff[5];
      cmd_word.lt_raw  = {eff[7], eff[6]};
      cmd_word.rt_raw  = {eff[9], eff[8]};
      cmd_word.lx_raw  = {eff[11], eff[10]};
      cmd_word.ly_raw  = {eff[13], eff[12]};
      cmd_word.rx_raw  = {eff[15], eff[14]};
      cmd_word.ry_raw  = {eff[17], eff[16]};
      cmd_push         = 1'b0;

      if (accept && (req_word.action == gfhr_pkg::ACTION_TICK)) begin
         cmd_push = 1'b1;
      end else if (byte_accept && req_word.frame_end) begin
         if (is_guide) begin
            cmd_word.kind = gfhr_pkg::CMD_GUIDE;
            cmd_push      = 1'b1;
         end else if (is_state) begin
            cmd_word.kind = gfhr_pkg::CMD_STATE;
            cmd_push      = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         pos_ff <= '0;
      end else begin
         pos_ff <= pos_in;
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < gfhr_pkg::CAP_DEPTH; k++) begin
         cap_ff[k] <= cap_in[k];
      end
   end

endmodule

>>> sv/gfhr_back.sv
// ----------------------------------------------------------------------------
// Gamepad frame to HID report: back end
// Executes commands in order: counts the guide latch down on ticks, applies
// guide events to the remembered report, and maps state frames to reports.
// ----------------------------------------------------------------------------
module gfhr_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   cmd_valid,
   input  gfhr_pkg::cmd_type      cmd_word,
   output logic                   cmd_pop,
   input  logic                   rsp_full,
   output logic                   rsp_push,
   output gfhr_pkg::rsp_word_type rsp_word,
   input  logic [15:0]            latch_ticks,
   input  logic [15:0]            trigger_floor
);

   logic                   guide_held_ff, guide_held_in;
   logic [15:0]            latch_ff, latch_in;
   gfhr_pkg::rsp_word_type prev_ff, prev_in;
   gfhr_pkg::rsp_word_type state_report;
   gfhr_pkg::rsp_word_type guide_report;
   logic                   is_tick;

   // Divide by 256 toward zero, then clamp the single value -128 to -127.
   function automatic logic signed [7:0] axis_scale(input logic [15:0] raw);
      logic signed [7:0] q;
      q = raw[15:8];
      if (raw[15] && (raw[7:0] != 8'h00)) begin
         q = q + 8'sd1;
      end
      if (q == 8'sh80) begin
         q = -8'sd127;
      end
      return q;
   endfunction

   function automatic logic [7:0] trigger_scale(input logic [15:0] raw,
                                                input logic [15:0] floor_level);
      logic [7:0] t;
      t = (raw < floor_level) ? 8'h00 : raw[9:2];
      return t;
   endfunction

   function automatic logic [3:0] hat_from(input logic [3:0] dpad);
      logic [3:0] h;
      // D-pad bits: up, down, left, right from bit 0.
      unique case ({dpad[0], dpad[1], dpad[2], dpad[3]})
         4'b1000: h = 4'd0;
         4'b1001: h = 4'd1;
         4'b0001: h = 4'd2;
         4'b0110: h = 4'd3;
         4'b0100: h = 4'd4;
         4'b0101: h = 4'd5;
         4'b0010: h = 4'd6;
         4'b1010: h = 4'd7;
         default: h = gfhr_pkg::HAT_NEUTRAL;
      endcase
      return h;
   endfunction

   assign is_tick  = (cmd_word.kind == gfhr_pkg::CMD_TICK);
   assign cmd_pop  = cmd_valid && (is_tick || !rsp_full);
   assign rsp_push = cmd_pop && !is_tick;
   assign rsp_word = (cmd_word.kind == gfhr_pkg::CMD_GUIDE) ? guide_report : state_report;

   always_comb begin
      state_report.buttons = {cmd_word.b5[7], cmd_word.b5[6],
                              guide_held_ff || (latch_ff != 16'd0),
                              cmd_word.b4[2], cmd_word.b4[3],
                              cmd_word.b5[5], cmd_word.b5[4],
                              cmd_word.b4[7], cmd_word.b4[6],
                              cmd_word.b4[5], cmd_word.b4[4]};
      state_report.hat           = hat_from(cmd_word.b5[3:0]);
      state_report.left_x        = axis_scale(cmd_word.lx_raw);
      state_report.left_y        = 8'sd0 - axis_scale(cmd_word.ly_raw);
      state_report.right_x       = axis_scale(cmd_word.rx_raw);
      state_report.right_y       = 8'sd0 - axis_scale(cmd_word.ry_raw);
      state_report.left_trigger  = trigger_scale(cmd_word.lt_raw, trigger_floor);
      state_report.right_trigger = trigger_scale(cmd_word.rt_raw, trigger_floor);

      guide_report = prev_ff;
      guide_report.buttons[gfhr_pkg::GUIDE_BUTTON_BIT] = cmd_word.pressed;
   end

   always_comb begin
      guide_held_in = guide_held_ff;
      latch_in      = latch_ff;
      prev_in       = prev_ff;
      if (cmd_pop) begin
         unique case (cmd_word.kind)
            gfhr_pkg::CMD_TICK: begin
               if (latch_ff != 16'd0) begin
                  latch_in = latch_ff - 16'd1;
               end
            end
            gfhr_pkg::CMD_GUIDE: begin
               guide_held_in = cmd_word.pressed;
               if (cmd_word.pressed) begin
                  latch_in = latch_ticks;
               end
               prev_in = guide_report;
            end
            gfhr_pkg::CMD_STATE: begin
               prev_in = state_report;
            end
            default: begin
               prev_in = prev_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         guide_held_ff <= 1'b0;
         latch_ff      <= '0;
         prev_ff       <= '0;
      end else begin
         guide_held_ff <= guide_held_in;
         latch_ff      <= latch_in;
         prev_ff       <= prev_in;
      end
   end

endmodule
